>>> sv/hashed_key_counter_table_top_assert.svh
// Assertion macros for the hashed key counter table.
`ifndef HASHED_KEY_COUNTER_TABLE_TOP_ASSERT_SVH
`define HASHED_KEY_COUNTER_TABLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HKCT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HKCT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HKCT_ASSERT(label, clk, rst_n, prop, msg)
`define HKCT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> sv/hkct_pkg.sv
// Shared types, codes, bucket hash constants and pre-multiply hash steps for the key counter table.
package hkct_pkg;
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_DEL = 2'd1;
	localparam logic [1:0] CMD_INC = 2'd2;
	localparam logic [1:0] CMD_LOOK = 2'd3;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOEFF = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;
	localparam logic [31:0] HASH_XOR = 32'd61;
	localparam logic [31:0] CNT_MAX = 32'hFFFFFFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] key_count;
		logic [31:0] total_count;
		logic [5:0]  total_entries;
	} result_t;

	// Hash steps before the multiply.
	function automatic logic [31:0] mix_pre(input logic [31:0] k);
		logic [31:0] a;
		a = (k ^ HASH_XOR) ^ (k >> 16);
		a = a + (a << 3);
		a = a ^ (a >> 4);
		return a;
	endfunction
endpackage

>>> sv/hkct_front.sv
// Front end: accept request, hash key into a bucket index over a few stages.
module hkct_front #(
	parameter int BUCKETS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [1:0]                     in_cmd,
	input  logic [31:0]                    in_key,
	output logic                           in_ready,
	output logic                           q_valid,
	output logic [1:0]                     q_cmd,
	output logic [31:0]                    q_key,
	output logic [$clog2(BUCKETS+1)-1:0]   q_bucket,
	input  logic                           q_ready
);
	import hkct_pkg::*;
	localparam int BW = $clog2(BUCKETS + 1);
	// reciprocal of BUCKETS, exact for every 32-bit hash value
	localparam int RSH = 32 + $clog2(BUCKETS);
	localparam logic [63:0] RECIP64 =
		((64'd1 << RSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [32:0] RECIP = RECIP64[32:0];

	logic        v_s1, v_s2;
	logic [1:0]  cmd_s1, cmd_s2;
	logic [31:0] key_s1, key_s2, pre_s1, h_s2;
	logic [31:0] prod, hfin;
	logic [64:0] qprod;
	logic [31:0] quo_q, rem_q;
	logic        busy_q, step_q;

	assign prod = pre_s1 * HASH_MUL;
	assign hfin = prod ^ (prod >> 15);
	assign qprod = 65'(h_s2) * 65'(RECIP);

	assign in_ready = !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			busy_q <= 1'b0;
			step_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (v_s1 && !v_s2) begin
				v_s1 <= 1'b0;
			end
			// remainder work: quotient, then subtract
			if (v_s1 && !v_s2) begin
				v_s2 <= 1'b1;
				busy_q <= 1'b1;
				step_q <= 1'b0;
			end else if (busy_q) begin
				if (step_q) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= 1'b1;
				end
			end else if (v_s2 && q_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= in_cmd;
			key_s1 <= in_key;
			pre_s1 <= mix_pre(in_key);
		end
		if (v_s1 && !v_s2) begin
			cmd_s2 <= cmd_s1;
			key_s2 <= key_s1;
			h_s2 <= hfin;
		end else if (busy_q) begin
			if (!step_q) quo_q <= 32'(qprod >> RSH);
			else rem_q <= h_s2 - quo_q * 32'(BUCKETS);
		end
	end

	assign q_valid = v_s2 && !busy_q;
	assign q_cmd = cmd_s2;
	assign q_key = key_s2;
	assign q_bucket = rem_q[BW-1:0];
endmodule

>>> sv/hkct_back.sv
// Back end: walk the bucket's ways, then update slot and totals.
module hkct_back #(
	parameter int BUCKETS = 8,
	parameter int WAYS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [1:0]                    q_cmd,
	input  logic [31:0]                   q_key,
	input  logic [$clog2(BUCKETS+1)-1:0]  q_bucket,
	output logic                          q_ready,
	output logic                          r_valid,
	output hkct_pkg::result_t             r_data,
	input  logic                          r_ready
);
	import hkct_pkg::*;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WC = $clog2(WAYS + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [SLOTS-1:0] valid_q;
	logic [31:0] key_mem [SLOTS];
	logic [31:0] cnt_mem [SLOTS];
	logic [2:0]  state_q;
	logic [1:0]  cmd_q;
	logic [31:0] key_q, rkey_q, rcnt_q, fcnt_q, total_q;
	logic [SW-1:0] base_q, found_q, free_q, rd_q;
	logic        found_v_q, free_v_q;
	logic [WC-1:0] way_q;
	logic [5:0]  entries_q;
	logic [1:0]  status_q;
	logic        hit_q;
	logic [31:0] kc_q;

	logic [SW-1:0] cur;
	assign cur = SW'(base_q + SW'(way_q));
	assign q_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			total_q <= '0;
			entries_q <= '0;
			found_v_q <= 1'b0;
			free_v_q <= 1'b0;
			way_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_SCAN;
						way_q <= '0;
						found_v_q <= 1'b0;
						free_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// issue read for current way; compare lands next cycle
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (valid_q[rd_q]) begin
						if (!found_v_q && rkey_q == key_q) found_v_q <= 1'b1;
					end else if (!free_v_q) begin
						free_v_q <= 1'b1;
					end
					if (way_q == WC'(WAYS - 1)) state_q <= S_EXEC;
					else begin
						way_q <= way_q + WC'(1);
						state_q <= S_SCAN;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					unique case (cmd_q)
						CMD_ADD: if (!found_v_q && free_v_q) begin
							valid_q[free_q] <= 1'b1;
							entries_q <= entries_q + 6'd1;
						end
						CMD_DEL: if (found_v_q) begin
							valid_q[found_q] <= 1'b0;
							total_q <= (total_q > fcnt_q) ? total_q - fcnt_q : '0;
							if (entries_q != 6'd0) entries_q <= entries_q - 6'd1;
						end
						CMD_INC: if (found_v_q && fcnt_q != CNT_MAX &&
							total_q != CNT_MAX) begin
							total_q <= total_q + 32'd1;
						end
						default: ;
					endcase
				end
				S_OUT: if (r_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memory reads and payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			cmd_q <= q_cmd;
			key_q <= q_key;
			base_q <= SW'(q_bucket) * SW'(WAYS);
		end
		if (state_q == S_SCAN) begin
			rkey_q <= key_mem[cur];
			rcnt_q <= cnt_mem[cur];
			rd_q <= cur;
		end
		if (state_q == S_WAIT) begin
			if (valid_q[rd_q]) begin
				if (!found_v_q && rkey_q == key_q) begin
					found_q <= rd_q;
					fcnt_q <= rcnt_q;
				end
			end else if (!free_v_q) begin
				free_q <= rd_q;
			end
		end
		if (state_q == S_EXEC) begin
			hit_q <= found_v_q;
			status_q <= ST_NOEFF;
			kc_q <= '0;
			unique case (cmd_q)
				CMD_ADD: begin
					if (found_v_q) kc_q <= fcnt_q;
					else if (free_v_q) begin
						key_mem[free_q] <= key_q;
						cnt_mem[free_q] <= '0;
						status_q <= ST_DONE;
					end else status_q <= ST_FULL;
				end
				CMD_DEL: if (found_v_q) status_q <= ST_DONE;
				CMD_INC: if (found_v_q) begin
					status_q <= ST_DONE;
					if (fcnt_q != CNT_MAX) begin
						cnt_mem[found_q] <= fcnt_q + 32'd1;
						kc_q <= fcnt_q + 32'd1;
					end else kc_q <= fcnt_q;
				end
				default: if (found_v_q) kc_q <= fcnt_q;
			endcase
		end
	end

	always_comb begin
		r_data.status = status_q;
		r_data.hit = hit_q;
		r_data.key_count = kc_q;
		r_data.total_count = total_q;
		r_data.total_entries = entries_q;
	end
	assign r_valid = (state_q == S_OUT);

	`include "hashed_key_counter_table_top_assert.svh"
	`HKCT_NEVER(a_entries_bound, clk, arst_n, entries_q > 6'(SLOTS), "entry count over slots")
	`HKCT_ASSERT(a_out_hold, clk, arst_n, (r_valid && !r_ready) |=> r_valid, "result dropped")
	`HKCT_ASSERT(a_exec_out, clk, arst_n, (state_q == S_EXEC) |=> (state_q == S_OUT), "exec skip")
endmodule

>>> sv/hashed_key_counter_table_top.sv
// Top level of the hashed key counter table.
// channel  | signals                                  | dir
// request  | push, full, command, key                 | in
// result   | pop, empty, status, hit, key_count,      | out
//          | total_count, total_entries               |
// In the front end a request is hashed (hash multiply), then its bucket is found
// by reciprocal quotient and remainder, overlapped with the previous request.
// The back end takes it, scans each way of the bucket with a read and a compare over
// the single slot memory port, updates the slot and presents the result until popped.
// Reset clears all slot valid bits and totals at once; no clearing pass.
// full is high while the front stage holds a request; result waits for pop.
module hashed_key_counter_table_top #(
	parameter int BUCKETS = 8,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [31:0] key,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic        hit,
	output logic [31:0] key_count,
	output logic [31:0] total_count,
	output logic [5:0]  total_entries
);
	import hkct_pkg::*;
	localparam int BW = $clog2(BUCKETS + 1);
	logic q_valid, q_ready, in_ready, r_valid;
	logic [1:0] q_cmd;
	logic [31:0] q_key;
	logic [BW-1:0] q_bucket;
	result_t r_data;

	hkct_front #(.BUCKETS(BUCKETS)) u_front (
		.clk, .arst_n, .in_valid(push), .in_cmd(command), .in_key(key),
		.in_ready, .q_valid, .q_cmd, .q_key, .q_bucket, .q_ready
	);
	hkct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_key, .q_bucket, .q_ready,
		.r_valid, .r_data, .r_ready(pop)
	);

	assign full = !in_ready;
	assign empty = !r_valid;
	assign status = r_data.status;
	assign hit = r_data.hit;
	assign key_count = r_data.key_count;
	assign total_count = r_data.total_count;
	assign total_entries = r_data.total_entries;
endmodule

>>> tb/sv/tb_top.sv
// Testbench for the hashed key counter table: random and directed requests.
`timescale 1ns / 1ps
module tb_top;
	import hkct_pkg::*;

	localparam int NBUCK = 8;
	localparam int NWAYS = 4;
	localparam int NSLOT = NBUCK * NWAYS;

	// Model of the table; predicts one result per request.
	class counter_table_sb;
		bit          vld[NSLOT];
		logic [31:0] skey[NSLOT];
		logic [31:0] scnt[NSLOT];
		logic [31:0] tot;
		int          ents;
		result_t     pending[$];
		int          errors;
		int          checked;

		function void clear();
			foreach (vld[i]) vld[i] = 0;
			tot = 0;
			ents = 0;
			errors = 0;
			checked = 0;
		endfunction

		function int bucket_of(logic [31:0] k);
			logic [31:0] a;
			a = (k ^ 32'd61) ^ (k >> 16);
			a = a + (a << 3);
			a = a ^ (a >> 4);
			a = a * 32'h27d4eb2d;
			a = a ^ (a >> 15);
			return int'(a % NBUCK);
		endfunction

		function void note_request(logic [1:0] cmd, logic [31:0] k);
			int b;
			int found;
			int free;
			result_t r;
			b = bucket_of(k) * NWAYS;
			found = -1;
			free = -1;
			for (int w = 0; w < NWAYS; w++) begin
				if (vld[b+w]) begin
					if (found < 0 && skey[b+w] == k) found = b + w;
				end else if (free < 0) begin
					free = b + w;
				end
			end
			r.status = ST_NOEFF;
			r.hit = found >= 0;
			r.key_count = 0;
			case (cmd)
				CMD_ADD: begin
					if (found >= 0) r.key_count = scnt[found];
					else if (free >= 0) begin
						vld[free] = 1;
						skey[free] = k;
						scnt[free] = 0;
						ents++;
						r.status = ST_DONE;
					end else r.status = ST_FULL;
				end
				CMD_DEL: begin
					if (found >= 0) begin
						tot = tot > scnt[found] ? tot - scnt[found] : 0;
						vld[found] = 0;
						if (ents > 0) ents--;
						r.status = ST_DONE;
					end
				end
				CMD_INC: begin
					if (found >= 0) begin
						if (scnt[found] != CNT_MAX) begin
							scnt[found]++;
							if (tot != CNT_MAX) tot++;
						end
						r.key_count = scnt[found];
						r.status = ST_DONE;
					end
				end
				default: begin
					if (found >= 0) r.key_count = scnt[found];
				end
			endcase
			r.total_count = tot;
			r.total_entries = ents > 63 ? 6'd63 : 6'(ents);
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
				errors++;
			end
			if (got.hit !== exp.hit) begin
				$display("%0t: hit exp %0d got %0d", $realtime, exp.hit, got.hit);
				errors++;
			end
			if (got.key_count !== exp.key_count) begin
				$display("%0t: key_count exp %h got %h", $realtime, exp.key_count,
					got.key_count);
				errors++;
			end
			if (got.total_count !== exp.total_count) begin
				$display("%0t: total_count exp %h got %h", $realtime, exp.total_count,
					got.total_count);
				errors++;
			end
			if (got.total_entries !== exp.total_entries) begin
				$display("%0t: total_entries exp %0d got %0d", $realtime,
					exp.total_entries, got.total_entries);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  command;
	logic [31:0] key;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic        hit;
	logic [31:0] key_count;
	logic [31:0] total_count;
	logic [5:0]  total_entries;

	counter_table_sb sb;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_pop;
	logic [31:0] key_pool[16];
	int          n_sent;

	hashed_key_counter_table_top #(.BUCKETS(NBUCK), .WAYS(NWAYS)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .key(key), .empty(empty), .pop(pop),
		.status(status), .hit(hit), .key_count(key_count),
		.total_count(total_count), .total_entries(total_entries)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Offer one request and hold it until accepted; push stays high into the next one unless an idle gap is drawn.
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] k);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		command <= cmd;
		key <= k;
		do @(posedge clk); while (full);
		sb.note_request(cmd, k);
		n_sent++;
	endtask

	// Pick mostly from a small key pool so that hits, full buckets and deletes happen.
	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 80) return key_pool[$urandom_range(15)];
		if (r < 90) return $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
		return $urandom;
	endfunction

	// Receiver side: pop with random stalls, check on each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result('{status, hit, key_count, total_count, total_entries});
			pop <= !hold_pop && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver stall while the sender keeps offering.
	initial begin
		hold_pop = 1'b0;
		wait (n_sent == 40);
		hold_pop = 1'b1;
		repeat (400) @(posedge clk);
		hold_pop = 1'b0;
	end

	initial begin
		sb = new();
		sb.clear();
		push = 1'b0;
		pop = 1'b0;
		command = CMD_ADD;
		key = '0;
		n_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFFFFFF;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command, extremes, absent keys, full buckets, lookups.
		send_request(CMD_INC, 32'h0);
		send_request(CMD_DEL, 32'hFFFFFFFF);
		send_request(CMD_LOOK, 32'h12345678);
		send_request(CMD_ADD, 32'h0);
		send_request(CMD_ADD, 32'h0);
		send_request(CMD_INC, 32'h0);
		send_request(CMD_INC, 32'h0);
		send_request(CMD_LOOK, 32'h0);
		send_request(CMD_ADD, 32'hFFFFFFFF);
		send_request(CMD_INC, 32'hFFFFFFFF);
		send_request(CMD_DEL, 32'h0);
		send_request(CMD_DEL, 32'h0);
		for (int i = 0; i < 12; i++) send_request(CMD_ADD, 32'hA5A50000 + i);

		send_idle_pct = 28;
		recv_idle_pct = 60;
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < 250; i++) begin
				logic [1:0] c;
				int r;
				r = $urandom_range(99);
				c = r < 30 ? CMD_ADD : r < 45 ? CMD_DEL : r < 90 ? CMD_INC : CMD_LOOK;
				send_request(c, pick_key());
			end
			send_idle_pct = ph == 0 ? 60 : 0;
			recv_idle_pct = ph == 0 ? 28 : 0;
		end
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, checked %0d results over add, delete, increment, lookup.",
			n_sent, sb.checked);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timeout");
		$display("Some tests failed");
		$finish;
	end
endmodule

>>> hashed_key_counter_table_top.f
+incdir+sv
sv/hkct_pkg.sv
sv/hkct_front.sv
sv/hkct_back.sv
sv/hashed_key_counter_table_top.sv
tb/sv/tb_top.sv
